// ===== sv/stereo_crossfeed_filter_defines.svh =====
// Assertion macros for the stereo crossfeed filter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STEREO_CROSSFEED_FILTER_DEFINES_SVH
`define STEREO_CROSSFEED_FILTER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SXF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sxf check failed");

// Next-cycle implication.
`define SXF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sxf check failed");

`else

`define SXF_ASSERT_IMP(label, clk, rst, ante, cons)
`define SXF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/sxf_pkg.sv =====
// Shared types and constants for the stereo crossfeed filter.
// Used by sxf_ctrl, sxf_dp and the top level; no dependencies.
package sxf_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int FILT_BITS      = 2;
   localparam int FILT_COUNT     = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWPASS_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWPASS_POLE    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_GAIN_NOW  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_GAIN_PREV = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHELF_POLE      = 3'd4;

   // Filter slots: bit 0 selects low-pass, bit 1 selects the right channel.
   localparam logic [FILT_BITS-1:0] FILT_L_SHELF = 2'd0;
   localparam logic [FILT_BITS-1:0] FILT_L_LOW   = 2'd1;
   localparam logic [FILT_BITS-1:0] FILT_R_SHELF = 2'd2;
   localparam logic [FILT_BITS-1:0] FILT_R_LOW   = 2'd3;
   localparam logic [FILT_BITS-1:0] FILT_LAST    = FILT_R_LOW;
   localparam int LOWPASS_BIT = 0;
   localparam int RIGHT_BIT   = 1;

   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_MUL_GAIN = 3'd1,
      OP_SUM_Y    = 3'd2,
      OP_MUL_LO   = 3'd3,
      OP_MUL_HI   = 3'd4,
      OP_FRAC     = 3'd5,
      OP_MEM      = 3'd6,
      OP_OUT      = 3'd7
   } op_type;

   typedef struct packed {
      logic                 load;
      op_type               op;
      logic [FILT_BITS-1:0] filt;
   } cmd_type;

endpackage

// ===== sv/sxf_ctrl.sv =====
// Sequencer for the crossfeed filter: steps each of the four filters through
// the shared multiplier and owns both handshakes. Depends on sxf_pkg and the defines header.
`include "stereo_crossfeed_filter_defines.svh"

module sxf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sxf_pkg::cmd_type cmd
);
   import sxf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_GAIN    = 8'b0000_0010,
      ST_SUMY    = 8'b0000_0100,
      ST_POLE_LO = 8'b0000_1000,
      ST_POLE_HI = 8'b0001_0000,
      ST_FRAC    = 8'b0010_0000,
      ST_MEM     = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [FILT_BITS-1:0] filt_ff, filt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_fire  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      filt_in  = filt_ff;
      cmd.load = req_valid && req_ready;
      cmd.op   = OP_NONE;
      cmd.filt = filt_ff;
      case (state_ff)
         ST_IDLE: begin
            filt_in = FILT_L_SHELF;
            if (req_valid) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.op   = OP_MUL_GAIN;
            state_in = ST_SUMY;
         end
         ST_SUMY: begin
            cmd.op   = OP_SUM_Y;
            state_in = ST_POLE_LO;
         end
         ST_POLE_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_POLE_HI;
         end
         ST_POLE_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            cmd.op   = OP_FRAC;
            state_in = ST_MEM;
         end
         ST_MEM: begin
            cmd.op = OP_MEM;
            if (filt_ff == FILT_LAST) begin
               state_in = ST_OUT;
            end else begin
               filt_in  = filt_ff + 2'd1;
               state_in = ST_GAIN;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_fire) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filt_ff      <= FILT_L_SHELF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SXF_ASSERT_NXT(a_accept_starts_left_shelf, clock, reset, req_valid && req_ready, state_ff == ST_GAIN && filt_ff == FILT_L_SHELF)
   `SXF_ASSERT_IMP(a_result_from_out_step, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)
   `SXF_ASSERT_NXT(a_pending_result_blocks, clock, reset, state_ff == ST_OUT && rsp_valid_ff && !rsp_ready, state_ff == ST_OUT)
   `SXF_ASSERT_NXT(a_last_filter_ends, clock, reset, state_ff == ST_MEM && filt_ff == FILT_LAST, state_ff == ST_OUT)

endmodule

// ===== sv/sxf_dp.sv =====
// Datapath of the crossfeed filter: coefficient registers, the shared multiplier,
// the four filter memories and the output register. Depends on sxf_pkg.
module sxf_dp #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sxf_pkg::cmd_type                    cmd,
   input  logic                                csr_write,
   input  logic [sxf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic signed [COEF_FRAC_BITS+1:0]    csr_data,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_in,
   output logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_right_out
);
   import sxf_pkg::*;

   localparam int CW = COEF_FRAC_BITS + 2;        // coefficient
   localparam int MW = SAMPLE_BITS + CW;          // filter value
   localparam int LB = MW / 2;                    // low split of a filter value
   localparam int BW = (SAMPLE_BITS > LB + 1) ? SAMPLE_BITS : LB + 1;
   localparam int PW = CW + BW;                   // multiplier product
   localparam int FW = CW + MW;                   // full pole product
   localparam int SW = MW + 3;                    // saturating sums
   localparam int RW = MW + 2;                    // output sum with rounding
   localparam int OW = RW - COEF_FRAC_BITS;       // output before clamp
   localparam logic signed [RW-1:0] ROUND_HALF = RW'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [CW-1:0] UNITY      = CW'(1) <<< COEF_FRAC_BITS;

   function automatic logic signed [MW-1:0] sat_mem(input logic signed [SW-1:0] v);
      logic signed [MW-1:0] r;
      if (v[SW-1:MW-1] == '0 || v[SW-1:MW-1] == '1) begin
         r = v[MW-1:0];
      end else if (v[SW-1]) begin
         r = {1'b1, {(MW-1){1'b0}}};
      end else begin
         r = {1'b0, {(MW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [OW-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v[OW-1:SAMPLE_BITS-1] == '0 || v[OW-1:SAMPLE_BITS-1] == '1) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (v[OW-1]) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   logic signed [CW-1:0]          lp_gain_ff, lp_gain_in;
   logic signed [CW-1:0]          lp_pole_ff, lp_pole_in;
   logic signed [CW-1:0]          sh_now_ff, sh_now_in;
   logic signed [CW-1:0]          sh_prev_ff, sh_prev_in;
   logic signed [CW-1:0]          sh_pole_ff, sh_pole_in;
   logic signed [SAMPLE_BITS-1:0] x_left_ff, x_left_in;
   logic signed [SAMPLE_BITS-1:0] x_right_ff, x_right_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [PW-1:0]          part_ff, part_in;
   logic signed [MW-1:0]          feed_ff, feed_in;
   logic signed [MW-1:0]          y_ff, y_in;
   logic signed [RW-1:0]          frac_ff, frac_in;
   logic signed [MW-1:0]          mem_ff [FILT_COUNT];
   logic signed [MW-1:0]          mem_in [FILT_COUNT];
   logic signed [MW-1:0]          ykeep_ff [FILT_COUNT];
   logic signed [MW-1:0]          ykeep_in [FILT_COUNT];
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_left_in;
   logic signed [SAMPLE_BITS-1:0] out_right_ff, out_right_in;

   logic                          lowpass;
   logic signed [SAMPLE_BITS-1:0] x_sel;
   logic signed [CW-1:0]          pole_sel;
   logic signed [CW-1:0]          mul_a;
   logic signed [BW-1:0]          mul_b;
   logic signed [PW-1:0]          mul_p;
   logic signed [SW-1:0]          y_sum;
   logic signed [SW-1:0]          mem_sum;
   logic signed [FW-1:0]          full_prod;
   logic signed [RW-1:0]          left_sum;
   logic signed [RW-1:0]          right_sum;

   assign lowpass  = cmd.filt[LOWPASS_BIT];
   assign x_sel    = cmd.filt[RIGHT_BIT] ? x_right_ff : x_left_ff;
   assign pole_sel = lowpass ? lp_pole_ff : sh_pole_ff;

   // Operand select for the shared multiplier.
   always_comb begin
      case (cmd.op)
         OP_MUL_GAIN: begin
            mul_a = lowpass ? lp_gain_ff : sh_now_ff;
            mul_b = BW'(x_sel);
         end
         OP_SUM_Y: begin
            // the low-pass has no feedforward into its memory
            mul_a = lowpass ? '0 : sh_prev_ff;
            mul_b = BW'(x_sel);
         end
         OP_MUL_LO: begin
            mul_a = pole_sel;
            mul_b = BW'({1'b0, y_ff[LB-1:0]});
         end
         OP_MUL_HI: begin
            mul_a = pole_sel;
            mul_b = BW'($signed(y_ff[MW-1:LB]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p     = mul_a * mul_b;
   assign y_sum     = SW'($signed(prod_ff[MW-1:0])) + SW'(mem_ff[cmd.filt]);
   assign mem_sum   = SW'(feed_ff) + SW'(frac_ff);
   assign full_prod = (FW'(prod_ff) <<< LB) + FW'(part_ff);
   assign left_sum  = RW'(ykeep_ff[FILT_L_SHELF]) + RW'(ykeep_ff[FILT_R_LOW]) + ROUND_HALF;
   assign right_sum = RW'(ykeep_ff[FILT_L_LOW]) + RW'(ykeep_ff[FILT_R_SHELF]) + ROUND_HALF;

   always_comb begin
      lp_gain_in   = lp_gain_ff;
      lp_pole_in   = lp_pole_ff;
      sh_now_in    = sh_now_ff;
      sh_prev_in   = sh_prev_ff;
      sh_pole_in   = sh_pole_ff;
      x_left_in    = x_left_ff;
      x_right_in   = x_right_ff;
      prod_in      = prod_ff;
      part_in      = part_ff;
      feed_in      = feed_ff;
      y_in         = y_ff;
      frac_in      = frac_ff;
      mem_in       = mem_ff;
      ykeep_in     = ykeep_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;

      if (csr_write) begin
         case (csr_index)
            REG_LOWPASS_GAIN:    lp_gain_in = csr_data;
            REG_LOWPASS_POLE:    lp_pole_in = csr_data;
            REG_SHELF_GAIN_NOW:  sh_now_in  = csr_data;
            REG_SHELF_GAIN_PREV: sh_prev_in = csr_data;
            REG_SHELF_POLE:      sh_pole_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.load) begin
         x_left_in  = req_left_in;
         x_right_in = req_right_in;
      end

      case (cmd.op)
         OP_MUL_GAIN: begin
            prod_in = mul_p;
         end
         OP_SUM_Y: begin
            y_in               = sat_mem(y_sum);
            ykeep_in[cmd.filt] = sat_mem(y_sum);
            prod_in            = mul_p;
         end
         OP_MUL_LO: begin
            feed_in = prod_ff[MW-1:0];
            prod_in = mul_p;
         end
         OP_MUL_HI: begin
            part_in = prod_ff;
            prod_in = mul_p;
         end
         OP_FRAC: begin
            frac_in = full_prod[FW-1:COEF_FRAC_BITS];
         end
         OP_MEM: begin
            mem_in[cmd.filt] = sat_mem(mem_sum);
         end
         OP_OUT: begin
            out_left_in  = sat_sample(left_sum[RW-1:COEF_FRAC_BITS]);
            out_right_in = sat_sample(right_sum[RW-1:COEF_FRAC_BITS]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_gain_ff <= '0;
         lp_pole_ff <= '0;
         sh_now_ff  <= UNITY;
         sh_prev_ff <= '0;
         sh_pole_ff <= '0;
         mem_ff     <= '{default: '0};
      end else begin
         lp_gain_ff <= lp_gain_in;
         lp_pole_ff <= lp_pole_in;
         sh_now_ff  <= sh_now_in;
         sh_prev_ff <= sh_prev_in;
         sh_pole_ff <= sh_pole_in;
         mem_ff     <= mem_in;
      end
   end

   always_ff @(posedge clock) begin
      x_left_ff    <= x_left_in;
      x_right_ff   <= x_right_in;
      prod_ff      <= prod_in;
      part_ff      <= part_in;
      feed_ff      <= feed_in;
      y_ff         <= y_in;
      frac_ff      <= frac_in;
      ykeep_ff     <= ykeep_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

endmodule

// ===== sv/stereo_crossfeed_filter.sv =====
// Channel   Handshake             Payload
// req       req_valid/req_ready   req_left_in, req_right_in
// rsp       rsp_valid/rsp_ready   rsp_left_out, rsp_right_out
// csr       csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// A pair passes through the idle cycle that accepts it, six steps for each of
// the four filters on the single shared multiplier and one output step; the result
// and rsp_valid are registered as the output step completes.
// Reset: shelf pass-through, other coefficients zero, filter memories cleared at once.
// The result waits in the output register while the next pair is taken; that pair
// holds in its output step only while the previous result is still untaken.
// Top level of the stereo crossfeed filter; depends on sxf_pkg, sxf_ctrl, sxf_dp.
module stereo_crossfeed_filter #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_right_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sxf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic signed [COEF_FRAC_BITS+1:0]    csr_data
);
   import sxf_pkg::*;

   cmd_type cmd;
   logic    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   sxf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sxf_dp #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stereo_crossfeed_filter: directed table, then random pairs.
// Keeps its own fixed-point crossfeed model; depends on sxf_pkg and the RTL only.
module testbench;
   import sxf_pkg::*;

   localparam int SAMPLE_W    = 24;
   localparam int FRAC_W      = 16;
   localparam int COEF_W      = FRAC_W + 2;
   localparam int MEM_W       = SAMPLE_W + FRAC_W + 2;
   localparam int SMAX        = 8388607;
   localparam int SMIN        = -8388608;
   localparam int CMAX        = 131071;
   localparam int CMIN        = -131072;
   localparam int UNITY       = 65536;
   localparam int HALF        = 32768;
   localparam int LEFT        = 0;
   localparam int RIGHT       = 1;
   localparam int REG_COUNT   = int'(REG_SHELF_POLE) + 1;
   localparam int REG_SPARE   = int'(REG_SHELF_POLE) + 1;
   localparam int REG_TOP     = (1 << CSR_INDEX_BITS) - 1;
   localparam int SEGMENTS    = 5;
   localparam int SEG_PAIRS   = 84;
   localparam int DRAIN_WAIT  = 60;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;
   localparam int PLAN_ROWS   = 36;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } pair_type;

   typedef enum logic [1:0] {ROW_PAIR, ROW_CHECKED, ROW_CSR} row_kind_type;

   // Pair rows: a/b are left/right samples. CSR rows: a is the index, b the data.
   typedef struct packed {
      row_kind_type kind;
      int           a;
      int           b;
      int           want_l;
      int           want_r;
   } plan_row_type;

   logic                          clock;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_left_in   = '0;
   logic signed [SAMPLE_W-1:0]    req_right_in  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_left_out;
   logic signed [SAMPLE_W-1:0]    rsp_right_out;
   logic                          csr_valid     = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index     = '0;
   logic signed [COEF_W-1:0]      csr_data      = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int pairs_sent    = 0;
   int cycle_count   = 0;

   pair_type pending_pairs [$];

   // Model state: coefficients by register index, filter memories by channel.
   logic signed [COEF_W-1:0] coef_bank [REG_COUNT];
   longint shelf_mem   [2] = '{0, 0};
   longint lowpass_mem [2] = '{0, 0};

   int tame_lo [REG_COUNT] = '{4000, 30000, 40000, -40000, 10000};
   int tame_hi [REG_COUNT] = '{24000, 63000, 70000, -10000, 45000};
   int send_mix  [3] = '{26, 83, 0};
   int stall_mix [3] = '{83, 26, 0};

   plan_row_type plan [0:PLAN_ROWS-1] = '{
      // pass-through after reset
      '{ROW_CHECKED, 0, 0, 0, 0},
      '{ROW_CHECKED, SMAX, SMIN, SMAX, SMIN},
      '{ROW_CHECKED, SMIN, SMAX, SMIN, SMAX},
      '{ROW_CHECKED, 1, -1, 1, -1},
      '{ROW_CHECKED, 5592405, -5592406, 5592405, -5592406},
      // all coefficients at the top: drive memories into saturation
      '{ROW_CSR, int'(REG_LOWPASS_GAIN), CMAX, 0, 0},
      '{ROW_CSR, int'(REG_LOWPASS_POLE), CMAX, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_GAIN_NOW), CMAX, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_GAIN_PREV), CMAX, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_POLE), CMAX, 0, 0},
      '{ROW_PAIR, SMAX, SMAX, 0, 0},
      '{ROW_PAIR, SMAX, SMAX, 0, 0},
      '{ROW_PAIR, SMAX, SMIN, 0, 0},
      '{ROW_PAIR, SMIN, SMIN, 0, 0},
      // all coefficients at the bottom
      '{ROW_CSR, int'(REG_LOWPASS_GAIN), CMIN, 0, 0},
      '{ROW_CSR, int'(REG_LOWPASS_POLE), CMIN, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_GAIN_NOW), CMIN, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_GAIN_PREV), CMIN, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_POLE), CMIN, 0, 0},
      '{ROW_PAIR, SMAX, SMIN, 0, 0},
      '{ROW_PAIR, SMIN, SMIN, 0, 0},
      '{ROW_PAIR, 0, 0, 0, 0},
      // writes past the last register must not land anywhere
      '{ROW_CSR, REG_SPARE, 12345, 0, 0},
      '{ROW_CSR, REG_TOP, -1, 0, 0},
      '{ROW_PAIR, SMIN, SMAX, 0, 0},
      // half-gain shelf, everything else off: rounding half up
      '{ROW_CSR, int'(REG_LOWPASS_GAIN), 0, 0, 0},
      '{ROW_CSR, int'(REG_LOWPASS_POLE), 0, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_GAIN_NOW), HALF, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_GAIN_PREV), 0, 0, 0},
      '{ROW_CSR, int'(REG_SHELF_POLE), 0, 0, 0},
      '{ROW_PAIR, 0, 0, 0, 0},
      '{ROW_CHECKED, 1, -1, 1, 0},
      '{ROW_CHECKED, 3, -3, 2, -1},
      '{ROW_CHECKED, SMAX, SMIN, 4194304, -4194304},
      '{ROW_CSR, int'(REG_SHELF_GAIN_NOW), UNITY, 0, 0},
      '{ROW_CHECKED, 123456, -654321, 123456, -654321}
   };

   stereo_crossfeed_filter #(
      .SAMPLE_BITS    (SAMPLE_W),
      .COEF_FRAC_BITS (FRAC_W)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint shelf_filter(longint x, int ch);
      longint y;
      y = clamp(longint'(coef_bank[REG_SHELF_GAIN_NOW]) * x + shelf_mem[ch], MEM_W);
      shelf_mem[ch] = clamp(longint'(coef_bank[REG_SHELF_GAIN_PREV]) * x
                            + ((longint'(coef_bank[REG_SHELF_POLE]) * y) >>> FRAC_W), MEM_W);
      return y;
   endfunction

   function automatic longint lowpass_filter(longint x, int ch);
      longint y;
      y = clamp(longint'(coef_bank[REG_LOWPASS_GAIN]) * x + lowpass_mem[ch], MEM_W);
      lowpass_mem[ch] = clamp((longint'(coef_bank[REG_LOWPASS_POLE]) * y) >>> FRAC_W, MEM_W);
      return y;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] round_to_sample(longint acc);
      return SAMPLE_W'(clamp((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, SAMPLE_W));
   endfunction

   function automatic pair_type predict_crossfeed(logic signed [SAMPLE_W-1:0] l,
                                                  logic signed [SAMPLE_W-1:0] r);
      longint l_shelf, l_low, r_low, r_shelf;
      pair_type res;
      l_shelf = shelf_filter(longint'(l), LEFT);
      l_low   = lowpass_filter(longint'(l), LEFT);
      r_low   = lowpass_filter(longint'(r), RIGHT);
      r_shelf = shelf_filter(longint'(r), RIGHT);
      res.left_out  = round_to_sample(l_shelf + r_low);
      res.right_out = round_to_sample(l_low + r_shelf);
      return res;
   endfunction

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return SAMPLE_W'(SMAX);
         1: return SAMPLE_W'(SMIN);
         2, 3: return SAMPLE_W'(rand_between(-4096, 4096));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] pick_coef(int lo, int hi);
      case ($urandom_range(7))
         0: return COEF_W'(CMAX);
         1: return COEF_W'(CMIN);
         2: return COEF_W'($urandom);
         default: return COEF_W'(rand_between(lo, hi));
      endcase
   endfunction

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   // Drop valid and hold until every pending pair has come back.
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pairs.size() != 0);
   endtask

   // One beat per call: drop valid after the accepting edge, then idle before returning.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic signed [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index <= REG_SHELF_POLE)
         coef_bank[index] = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r,
                            input bit typed, input int want_l, input int want_r);
      pair_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      do @(posedge clock); while (!req_ready);
      predicted = predict_crossfeed(l, r);
      if (typed) begin
         predicted.left_out  = SAMPLE_W'(want_l);
         predicted.right_out = SAMPLE_W'(want_r);
      end
      pending_pairs.push_back(predicted);
      pairs_sent++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pairs pending", cycle_count,
                  pending_pairs.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            report_error($sformatf("result %0d/%0d with no pair pending",
                                   rsp_left_out, rsp_right_out));
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_left_out !== want.left_out)
               report_error($sformatf("left_out got %0d want %0d",
                                      rsp_left_out, want.left_out));
            if (rsp_right_out !== want.right_out)
               report_error($sformatf("right_out got %0d want %0d",
                                      rsp_right_out, want.right_out));
         end
      end
   end

   initial begin
      bit wild;
      coef_bank[REG_LOWPASS_GAIN]    = '0;
      coef_bank[REG_LOWPASS_POLE]    = '0;
      coef_bank[REG_SHELF_GAIN_NOW]  = COEF_W'(UNITY);
      coef_bank[REG_SHELF_GAIN_PREV] = '0;
      coef_bank[REG_SHELF_POLE]      = '0;
      send_idle_pct = send_mix[0];
      stall_pct     = stall_mix[0];

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_CSR: begin
               quiesce();
               write_csr(CSR_INDEX_BITS'(plan[i].a), COEF_W'(plan[i].b));
            end
            ROW_PAIR:
               send_pair(SAMPLE_W'(plan[i].a), SAMPLE_W'(plan[i].b), 1'b0, 0, 0);
            default:
               send_pair(SAMPLE_W'(plan[i].a), SAMPLE_W'(plan[i].b), 1'b1,
                         plan[i].want_l, plan[i].want_r);
         endcase
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = send_mix[ph];
         stall_pct     = stall_mix[ph];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            // mostly a plausible crossfeed setting, sometimes anything at all
            wild = ($urandom_range(3) == 0);
            for (int r = 0; r < REG_COUNT; r++)
               write_csr(CSR_INDEX_BITS'(r),
                         wild ? COEF_W'($urandom) : pick_coef(tame_lo[r], tame_hi[r]));
            if ($urandom_range(2) == 0)
               write_csr(CSR_INDEX_BITS'(rand_between(REG_SPARE, REG_TOP)), COEF_W'($urandom));
            for (int n = 0; n < SEG_PAIRS; n++) begin
               if (n == SEG_PAIRS / 2 && seg == 0)
                  quiesce();
               send_pair(pick_sample(), pick_sample(), 1'b0, 0, 0);
            end
         end
      end

      quiesce();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
